[rtl/gradient_pattern_cursor_overlay_defines.svh]
// Assertion macros used by the gradient pattern cursor overlay back end.
`ifndef GRADIENT_PATTERN_CURSOR_OVERLAY_DEFINES_SVH
`define GRADIENT_PATTERN_CURSOR_OVERLAY_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define GPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define GPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gpc_pkg.sv]
// Types, constants and register codes of the gradient pattern cursor overlay.
package gpc_pkg;

  localparam int unsigned COORD_W     = 12;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned DELTA_W     = 16;
  localparam int unsigned DEVICE_W    = 4;
  localparam int unsigned AXIS_W      = 2;
  localparam int unsigned PROD_W      = COORD_W + COLOR_W;
  localparam int unsigned CURSOR_SIZE = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [COORD_W-1:0] WIDTH_RESET  = 12'd800;
  localparam logic [COORD_W-1:0] HEIGHT_RESET = 12'd600;
  localparam logic [COLOR_W-1:0] COLOR_MAX    = 8'd255;

  localparam logic [DEVICE_W-1:0] MOUSE_DEVICE = 4'd0;
  localparam logic [AXIS_W-1:0]   AXIS_X       = 2'd0;
  localparam logic [AXIS_W-1:0]   AXIS_Y       = 2'd1;

  typedef enum logic [0:0] {
    FUNC_MOTION = 1'b0,
    FUNC_PIXEL  = 1'b1
  } func_e;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_MOVE_X = 2'd1,
    OP_MOVE_Y = 2'd2,
    OP_PIXEL  = 2'd3
  } op_e;

  typedef struct packed {
    logic                      func;
    logic [DEVICE_W-1:0]       device;
    logic [AXIS_W-1:0]         axis;
    logic signed [DELTA_W-1:0] delta;
    logic [COORD_W-1:0]        pixel_x;
    logic [COORD_W-1:0]        pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               in_cursor;
    logic               outside;
    logic [COORD_W-1:0] cursor_col;
    logic [COORD_W-1:0] cursor_row;
  } out_item_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    op_e                       op;
    logic signed [DELTA_W-1:0] delta;
    logic [COORD_W-1:0]        pixel_x;
    logic [COORD_W-1:0]        pixel_y;
  } cmd_t;

endpackage

[rtl/gpc_if.sv]
// Valid/ready stream interfaces for the input and result channels.
interface gpc_in_if;
  import gpc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface gpc_out_if;
  import gpc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/gpc_front.sv]
// Front end: accepts input items and classifies them into commands.
module gpc_front (
  gpc_in_if.sink      in_s,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output gpc_pkg::cmd_t push_cmd_o
);
  import gpc_pkg::*;

  always_comb begin
    push_cmd_o.delta   = in_s.payload.delta;
    push_cmd_o.pixel_x = in_s.payload.pixel_x;
    push_cmd_o.pixel_y = in_s.payload.pixel_y;
    push_cmd_o.op      = OP_NOP;
    if (func_e'(in_s.payload.func) == FUNC_PIXEL) begin
      push_cmd_o.op = OP_PIXEL;
    end else if (in_s.payload.device == MOUSE_DEVICE) begin
      if (in_s.payload.axis == AXIS_X) begin
        push_cmd_o.op = OP_MOVE_X;
      end else if (in_s.payload.axis == AXIS_Y) begin
        push_cmd_o.op = OP_MOVE_Y;
      end
    end
  end

  assign push_valid_o = in_s.valid;
  assign in_s.ready   = push_ready_i;

endmodule

[rtl/gpc_queue.sv]
// Short command queue between the front end and the back end.
module gpc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  gpc_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output gpc_pkg::cmd_t pop_cmd_o
);
  import gpc_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[rtl/gpc_div.sv]
// Serial restoring divider producing one quotient bit per cycle.
module gpc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gpc_pkg::PROD_W-1:0]    dividend_i,
  input  logic [gpc_pkg::COORD_W-1:0]   divisor_i,
  output logic                          busy_o,
  output logic [gpc_pkg::COLOR_W-1:0]   quot_o
);
  import gpc_pkg::*;

  localparam int unsigned STEP_W = $clog2(COLOR_W);

  // The dividend is below 256 times the divisor, so the upper bits start
  // as a valid partial remainder and the quotient fits in COLOR_W bits.
  logic [COORD_W-1:0] rem_q, rem_d;
  logic [COLOR_W-1:0] shift_q, shift_d;
  logic [COORD_W-1:0] divisor_q;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               busy_q, busy_d;
  logic [COORD_W:0]   trial;
  logic               fits;

  assign trial = {rem_q, shift_q[COLOR_W-1]};
  assign fits  = (trial >= {1'b0, divisor_q});

  always_comb begin
    rem_d   = rem_q;
    shift_d = shift_q;
    step_d  = step_q;
    busy_d  = busy_q;
    if (start_i) begin
      rem_d   = dividend_i[PROD_W-1:COLOR_W];
      shift_d = dividend_i[COLOR_W-1:0];
      step_d  = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      rem_d   = fits ? COORD_W'(trial - {1'b0, divisor_q}) : trial[COORD_W-1:0];
      shift_d = {shift_q[COLOR_W-2:0], fits};
      step_d  = step_q + 1'b1;
      if (step_q == STEP_W'(COLOR_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    shift_q <= shift_d;
    if (start_i) begin
      divisor_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = shift_q;

endmodule

[rtl/gpc_back.sv]
// Back end: applies cursor motion, shades pixels and holds the result register.
`include "gradient_pattern_cursor_overlay_defines.svh"

module gpc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  gpc_pkg::cmd_t               cmd_i,
  input  logic [gpc_pkg::COORD_W-1:0] image_width_i,
  input  logic [gpc_pkg::COORD_W-1:0] image_height_i,
  gpc_out_if.source                   out_s
);
  import gpc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_e;

  // Adds a signed delta and clamps to zero and to size minus the cursor size.
  function automatic logic [COORD_W-1:0] clamp_coord(
    logic [COORD_W-1:0]        cur,
    logic signed [DELTA_W-1:0] d,
    logic [COORD_W-1:0]        size
  );
    logic signed [COORD_W:0]   lim;
    logic signed [DELTA_W+1:0] sum;
    logic signed [DELTA_W+1:0] lim_ext;
    logic [COORD_W-1:0]        res;
    lim = $signed({1'b0, size}) - $signed((COORD_W + 1)'(CURSOR_SIZE));
    if (lim < 0) begin
      lim = '0;
    end
    sum     = $signed({{(DELTA_W + 2 - COORD_W){1'b0}}, cur})
            + $signed({{2{d[DELTA_W-1]}}, d});
    lim_ext = $signed({{(DELTA_W + 1 - COORD_W){lim[COORD_W]}}, lim});
    if (sum < 0) begin
      res = '0;
    end else if (sum >= lim_ext) begin
      res = lim[COORD_W-1:0];
    end else begin
      res = sum[COORD_W-1:0];
    end
    return res;
  endfunction

  state_e             state_q, state_d;
  logic [COORD_W-1:0] left_q, left_d;
  logic [COORD_W-1:0] top_q, top_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  logic               out_free;
  logic               pop;
  logic               div_start;
  logic               busy_r, busy_g;
  logic [COLOR_W-1:0] quot_r, quot_g;
  logic [PROD_W-1:0]  prod_x, prod_y;
  logic               outside, hit;

  assign out_free    = !out_valid_q || out_s.ready;
  assign cmd_ready_o = (state_q == ST_IDLE) && out_free;
  assign pop         = cmd_valid_i && cmd_ready_o;

  // Multiply by 255 as a shift and a subtract.
  assign prod_x = {cmd_i.pixel_x, {COLOR_W{1'b0}}} - PROD_W'(cmd_i.pixel_x);
  assign prod_y = {cmd_i.pixel_y, {COLOR_W{1'b0}}} - PROD_W'(cmd_i.pixel_y);

  assign outside = (cmd_i.pixel_x >= image_width_i) || (cmd_i.pixel_y >= image_height_i);
  assign hit = ({1'b0, cmd_i.pixel_x} >= {1'b0, left_q})
            && ({1'b0, cmd_i.pixel_x} < ({1'b0, left_q} + (COORD_W + 1)'(CURSOR_SIZE)))
            && ({1'b0, cmd_i.pixel_y} >= {1'b0, top_q})
            && ({1'b0, cmd_i.pixel_y} < ({1'b0, top_q} + (COORD_W + 1)'(CURSOR_SIZE)));

  always_comb begin
    state_d     = state_q;
    left_d      = left_q;
    top_d       = top_q;
    out_d       = out_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && !out_s.ready;

    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          out_d.red       = '0;
          out_d.green     = '0;
          out_d.blue      = '0;
          out_d.in_cursor = 1'b0;
          out_d.outside   = 1'b0;
          out_valid_d     = 1'b1;
          case (cmd_i.op)
            OP_MOVE_X: left_d = clamp_coord(left_q, cmd_i.delta, image_width_i);
            OP_MOVE_Y: top_d  = clamp_coord(top_q, cmd_i.delta, image_height_i);
            OP_PIXEL: begin
              if (outside) begin
                out_d.outside = 1'b1;
              end else if (hit) begin
                out_d.red       = COLOR_MAX;
                out_d.green     = COLOR_MAX;
                out_d.blue      = COLOR_MAX;
                out_d.in_cursor = 1'b1;
              end else begin
                div_start   = 1'b1;
                out_d       = out_q;
                out_valid_d = out_valid_q && !out_s.ready;
                state_d     = ST_DIV;
              end
            end
            default: ;
          endcase
          out_d.cursor_col = left_d;
          out_d.cursor_row = top_d;
        end
      end
      ST_DIV: begin
        if (!busy_r && !busy_g && out_free) begin
          out_d.red        = quot_r;
          out_d.green      = quot_g;
          out_d.blue       = COLOR_MAX - quot_r;
          out_d.in_cursor  = 1'b0;
          out_d.outside    = 1'b0;
          out_d.cursor_col = left_q;
          out_d.cursor_row = top_q;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  gpc_div u_div_red (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_x),
    .divisor_i  (image_width_i),
    .busy_o     (busy_r),
    .quot_o     (quot_r)
  );

  gpc_div u_div_green (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_y),
    .divisor_i  (image_height_i),
    .busy_o     (busy_g),
    .quot_o     (quot_g)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      left_q      <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_q      <= left_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_s.valid   = out_valid_q;
  assign out_s.payload = out_q;

  `GPC_ASSERT_NOW(a_no_pop_while_dividing, state_q == ST_DIV, !pop,
    "command taken while the dividers are running")
  `GPC_ASSERT_NEXT(a_div_starts, div_start, busy_r && busy_g && state_q == ST_DIV,
    "dividers did not start together")
  `GPC_ASSERT_NOW(a_cursor_white, out_valid_q && out_q.in_cursor,
    out_q.red == COLOR_MAX && out_q.green == COLOR_MAX && out_q.blue == COLOR_MAX
    && !out_q.outside, "cursor pixel is not white")
  `GPC_ASSERT_NOW(a_outside_black, out_valid_q && out_q.outside,
    out_q.red == '0 && out_q.green == '0 && out_q.blue == '0 && !out_q.in_cursor,
    "pixel outside the image is not black")

endmodule

[rtl/gradient_pattern_cursor_overlay.sv]
// Gradient test pattern generator with a movable cursor square.
//
//   channel   direction  handshake      payload
//   in_s      sink       valid/ready    func, device, axis, delta, pixel_x, pixel_y
//   out_s     source     valid/ready    red, green, blue, in_cursor, outside, cursor
//   cfg       write      cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// Motion events, pixels outside the image and pixels inside the cursor finish
// in the idle state. A gradient pixel starts the serial dividers (one quotient
// bit per cycle) and loads the result when both are done and the result register
// is free. A two-entry command queue accepts input while the back end is busy,
// until it is full. The result register holds its transfer until out_s.ready;
// reset puts the cursor in the top left corner and the image at 800 by 600.
module gradient_pattern_cursor_overlay (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gpc_in_if.sink                      in_s,
  gpc_out_if.source                   out_s,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [gpc_pkg::COORD_W-1:0] cfg_wdata_i
);
  import gpc_pkg::*;

  logic [COORD_W-1:0] width_q, height_q;
  logic               push_valid, push_ready;
  cmd_t               push_cmd;
  logic               pop_valid, pop_ready;
  cmd_t               pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  gpc_front u_front (
    .in_s         (in_s),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  gpc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  gpc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (pop_valid),
    .cmd_ready_o    (pop_ready),
    .cmd_i          (pop_cmd),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .out_s          (out_s)
  );

endmodule

[test/tb_gradient_pattern_cursor_overlay.sv]
// Self-checking testbench of the gradient pattern generator with cursor overlay.
module tb_gradient_pattern_cursor_overlay;
  import gpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE      = 12;
  localparam int unsigned MAX_IDLE    = 13;
  localparam int unsigned HOLD_CYCLES = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_reg_e            cfg_idx;
  logic [COORD_W-1:0]  cfg_wdata;

  gpc_in_if  in_bus ();
  gpc_out_if out_bus ();

  gradient_pattern_cursor_overlay dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_s        (in_bus),
    .out_s       (out_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state: image size and cursor corner as the block should hold them.
  logic [COORD_W-1:0] frame_w = WIDTH_RESET;
  logic [COORD_W-1:0] frame_h = HEIGHT_RESET;
  logic [COORD_W-1:0] ptr_x   = '0;
  logic [COORD_W-1:0] ptr_y   = '0;

  out_item_t   predicted_colors[$];
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned n_motion     = 0;
  int unsigned n_gradient   = 0;
  int unsigned n_cursor     = 0;
  int unsigned n_outside    = 0;
  bit          idle_on      = 1'b1;
  bit          hold_req     = 1'b0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               predicted_colors.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Adds a signed step to a cursor coordinate and clamps it to the image.
  function automatic logic [COORD_W-1:0] clamp_step(logic [COORD_W-1:0] pos,
                                                    logic signed [DELTA_W-1:0] d,
                                                    logic [COORD_W-1:0] size);
    int lim;
    int v;
    lim = int'(size) - int'(CURSOR_SIZE);
    if (lim < 0) lim = 0;
    v = int'(pos) + int'(d);
    if (v < 0) v = 0;
    else if (v >= lim) v = lim;
    return v[COORD_W-1:0];
  endfunction

  // Works out the result of one accepted item and advances the cursor state.
  function automatic out_item_t shade_item(in_item_t it);
    out_item_t res;
    int        px;
    int        py;
    res = '0;
    px  = int'(it.pixel_x);
    py  = int'(it.pixel_y);
    if (func_e'(it.func) == FUNC_MOTION) begin
      if (it.device == MOUSE_DEVICE) begin
        if (it.axis == AXIS_X) ptr_x = clamp_step(ptr_x, it.delta, frame_w);
        else if (it.axis == AXIS_Y) ptr_y = clamp_step(ptr_y, it.delta, frame_h);
      end
    end else if (px >= int'(frame_w) || py >= int'(frame_h)) begin
      res.outside = 1'b1;
    end else if (px >= int'(ptr_x) && px < int'(ptr_x) + int'(CURSOR_SIZE) &&
                 py >= int'(ptr_y) && py < int'(ptr_y) + int'(CURSOR_SIZE)) begin
      res.red       = COLOR_MAX;
      res.green     = COLOR_MAX;
      res.blue      = COLOR_MAX;
      res.in_cursor = 1'b1;
    end else begin
      res.red   = 8'(px * 255 / int'(frame_w));
      res.green = 8'(py * 255 / int'(frame_h));
      res.blue  = COLOR_MAX - res.red;
    end
    res.cursor_col = ptr_x;
    res.cursor_row = ptr_y;
    return res;
  endfunction

  function automatic in_item_t motion_item(logic [DEVICE_W-1:0] dev, logic [AXIS_W-1:0] ax,
                                           logic signed [DELTA_W-1:0] d);
    in_item_t it;
    it         = '0;
    it.func    = FUNC_MOTION;
    it.device  = dev;
    it.axis    = ax;
    it.delta   = d;
    it.pixel_x = COORD_W'($urandom);
    it.pixel_y = COORD_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t pixel_item(int x, int y);
    in_item_t it;
    it         = '0;
    it.func    = FUNC_PIXEL;
    it.device  = DEVICE_W'($urandom);
    it.axis    = AXIS_W'($urandom);
    it.delta   = DELTA_W'($urandom);
    it.pixel_x = COORD_W'(x);
    it.pixel_y = COORD_W'(y);
    return it;
  endfunction

  function automatic int near_cursor(logic [COORD_W-1:0] corner);
    int v;
    v = int'(corner) + int'($urandom_range(0, CURSOR_SIZE + 8)) - 4;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  // Mostly pixels inside the image or around the cursor and moves of device 0.
  function automatic in_item_t random_item();
    int unsigned pick;
    int unsigned sel;
    int          x;
    int          y;
    logic signed [DELTA_W-1:0] d;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 3);
    if (pick < 50) begin
      x = $urandom_range(0, 4095);
      y = $urandom_range(0, 4095);
      if (sel == 3) begin
        x = near_cursor(ptr_x);
        y = near_cursor(ptr_y);
      end else if (sel != 0) begin
        if (frame_w != 0) x = $urandom_range(0, int'(frame_w) - 1);
        if (frame_h != 0) y = $urandom_range(0, int'(frame_h) - 1);
      end
      return pixel_item(x, y);
    end
    case (sel)
      0:       d = DELTA_W'($urandom);
      1:       d = DELTA_W'($urandom_range(0, 128)) - 16'sd64;
      2:       d = DELTA_W'($urandom_range(0, 1024)) - 16'sd512;
      default: d = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
    if (pick < 85) return motion_item(MOUSE_DEVICE, AXIS_W'($urandom_range(0, 1)), d);
    return motion_item(DEVICE_W'($urandom), AXIS_W'($urandom), d);
  endfunction

  // Offers one item, after a random gap while idle_on is set, and records its prediction on transfer.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.payload <= it;
    do @(posedge clk_i); while (!in_bus.ready);
    predicted_colors.push_back(shade_item(it));
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (predicted_colors.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Waits for the block to go idle, then writes both size registers.
  task automatic resize_image(logic [COORD_W-1:0] w, logic [COORD_W-1:0] h);
    drain();
    cfg_we_i  <= 1'b1;
    cfg_idx   <= REG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk_i);
    cfg_idx   <= REG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    frame_w = w;
    frame_h = h;
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_item(random_item());
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Result side: random stalls, a long hold-off when hold_req is set, and the comparison.
  initial begin : result_side
    int unsigned wait_left;
    out_item_t   want;
    out_item_t   got;
    wait_left = 0;
    out_bus.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) begin
        got = out_bus.payload;
        if (predicted_colors.size() == 0) begin
          $error("Result transfer with no item outstanding");
          error_count++;
        end else begin
          want = predicted_colors.pop_front();
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("in_cursor", want.in_cursor, got.in_cursor);
          check_field("outside", want.outside, got.outside);
          check_field("cursor_col", want.cursor_col, got.cursor_col);
          check_field("cursor_row", want.cursor_row, got.cursor_row);
          if (want.in_cursor) n_cursor++;
          else if (want.outside) n_outside++;
          else if (want.red == 0 && want.green == 0 && want.blue == 0) n_motion++;
          else n_gradient++;
        end
        wait_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (hold_req) begin
        wait_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (wait_left > 0) begin
        out_bus.ready <= 1'b0;
        wait_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Corners, the cursor edges, outside pixels, clamping and ignored motion.
  task automatic test_directed();
    send_item(pixel_item(0, 0));
    send_item(pixel_item(31, 31));
    send_item(pixel_item(32, 0));
    send_item(pixel_item(0, 32));
    send_item(pixel_item(799, 599));
    send_item(pixel_item(800, 0));
    send_item(pixel_item(0, 600));
    send_item(pixel_item(4095, 4095));
    send_item(motion_item(MOUSE_DEVICE, AXIS_X, 16'sd100));
    send_item(motion_item(MOUSE_DEVICE, AXIS_Y, 16'sh7fff));
    send_item(motion_item(MOUSE_DEVICE, AXIS_X, 16'sh8000));
    send_item(motion_item(4'd15, AXIS_X, 16'sd50));
    send_item(motion_item(4'd1, AXIS_Y, -16'sd50));
    send_item(motion_item(MOUSE_DEVICE, 2'd2, 16'sd50));
    send_item(motion_item(MOUSE_DEVICE, 2'd3, 16'sd50));
    // Landing exactly on the right limit, then pushing past it.
    send_item(motion_item(MOUSE_DEVICE, AXIS_X, 16'sd768));
    send_item(motion_item(MOUSE_DEVICE, AXIS_X, 16'sd1));
    send_item(pixel_item(768, 568));
    send_item(pixel_item(767, 568));
    send_item(pixel_item(799, 599));
    send_item(pixel_item(800, 599));
    send_item(pixel_item(768, 567));
    send_item(motion_item(MOUSE_DEVICE, AXIS_Y, -16'sd1));
    send_item(pixel_item(799, 598));
  endtask

  task automatic test_reset_size();
    send_random(50);
  endtask

  task automatic test_largest_image();
    resize_image(12'd4095, 12'd4095);
    send_item(pixel_item(4094, 4094));
    send_item(motion_item(MOUSE_DEVICE, AXIS_X, 16'sh7fff));
    send_item(motion_item(MOUSE_DEVICE, AXIS_Y, 16'sh7fff));
    send_item(pixel_item(4094, 4094));
    send_random(80);
  endtask

  task automatic test_smallest_image();
    resize_image(12'd33, 12'd33);
    send_random(60);
  endtask

  // Sizes below the cursor pin it to the corner; a zero size puts every pixel outside.
  task automatic test_tiny_image();
    resize_image(12'd20, 12'd0);
    send_random(30);
    resize_image(12'd1, 12'd31);
    send_random(30);
  endtask

  task automatic test_no_idling();
    resize_image(12'd641, 12'd37);
    idle_on = 1'b0;
    send_random(60);
    drain();
    idle_on = 1'b1;
  endtask

  // The result side stops for a long stretch while items keep arriving back to back.
  task automatic test_backpressure();
    resize_image(WIDTH_RESET, HEIGHT_RESET);
    idle_on  = 1'b0;
    hold_req = 1'b1;
    send_random(40);
    drain();
    idle_on = 1'b1;
  endtask

  task automatic test_random_sizes();
    repeat (4) begin
      resize_image(COORD_W'($urandom_range(33, 4095)), COORD_W'($urandom_range(33, 4095)));
      send_random(20);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx        = REG_IMAGE_WIDTH;
    cfg_wdata      = '0;
    in_bus.valid   = 1'b0;
    in_bus.payload = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_reset_size();
    test_largest_image();
    test_smallest_image();
    test_tiny_image();
    test_no_idling();
    test_backpressure();
    test_random_sizes();
    drain();
    $display("Checked %0d motion, %0d gradient, %0d cursor and %0d outside results",
             n_motion, n_gradient, n_cursor, n_outside);
    $display("over image sizes from zero up to 4095 and a long result-side stall.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[gradient_pattern_cursor_overlay.f]
+incdir+rtl
rtl/gpc_pkg.sv
rtl/gpc_if.sv
rtl/gpc_front.sv
rtl/gpc_queue.sv
rtl/gpc_div.sv
rtl/gpc_back.sv
rtl/gradient_pattern_cursor_overlay.sv
test/tb_gradient_pattern_cursor_overlay.sv
